FILE: rtl/lrl_pkg.sv
// ----------------------------------------------------------------------------
// lrl_pkg: shared types and constants of the LRU recency list
// Widths, command and status codes, and the structs that travel between the
// sequencer and the node memories.
// ----------------------------------------------------------------------------
`default_nettype none

package lrl_pkg;

  localparam int SLOTS        = 256;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int CNT_W        = $clog2(SLOTS + 1);
  localparam int PAYLOAD_BITS = 32;
  localparam int CMD_W        = 3;
  localparam int HANDLE_W     = 8;
  localparam int PIN_W        = 32;
  localparam int POUT_W       = 32;
  localparam int SLOT_OUT_W   = 8;
  localparam int STAT_W       = 3;
  localparam int OCC_W        = 9;

  localparam int IN_BITS      = CMD_W + HANDLE_W + PIN_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = POUT_W + SLOT_OUT_W + STAT_W + OCC_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_TOUCH  = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_PREV   = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_EMPTY  = 3'd1,
    STAT_FULL   = 3'd2,
    STAT_BADHND = 3'd3,
    STAT_ATHEAD = 3'd4
  } stat_t;

  // write and read requests to the node memories
  typedef struct packed {
    logic                    pl_we;
    logic [SLOT_W-1:0]       pl_waddr;
    logic [PAYLOAD_BITS-1:0] pl_wdata;
    logic [SLOT_W-1:0]       pl_raddr;
    logic                    thl_we;
    logic [SLOT_W-1:0]       thl_waddr;
    logic [SLOT_W-1:0]       thl_wdata;
    logic                    ttl_we;
    logic [SLOT_W-1:0]       ttl_waddr;
    logic [SLOT_W-1:0]       ttl_wdata;
    logic [SLOT_W-1:0]       lk_raddr;
    logic                    fs_we;
    logic [SLOT_W-1:0]       fs_waddr;
    logic [SLOT_W-1:0]       fs_wdata;
    logic [SLOT_W-1:0]       fs_raddr;
  } mem_req_t;

  // registered read data of the node memories
  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] pl;
    logic [SLOT_W-1:0]       thl;
    logic [SLOT_W-1:0]       ttl;
    logic [SLOT_W-1:0]       fs;
  } mem_rsp_t;

  // one finished result
  typedef struct packed {
    logic [OCC_W-1:0]      occupancy;
    logic [STAT_W-1:0]     status;
    logic [SLOT_OUT_W-1:0] slot_out;
    logic [POUT_W-1:0]     payload_out;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/lru_recency_list_unit.sv
// ----------------------------------------------------------------------------
// lru_recency_list_unit: recency-ordered list of slots with LRU eviction
// Node memories, command sequencer and output register.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_ channel, one beat per command, and each command
//   gives exactly one result beat on the m_ channel. Commands are push, pop
//   tail, peek tail, touch to head, remove and read previous.
//   Rejected commands, touch at head and unused codes go straight to the
//   result. Other commands first load with a registered read (a push from
//   a fresh slot skips it), then unlink, relink and update the head as
//   each needs, one after another, since each link memory has a single
//   write port; peek only loads, and read previous then reads the node
//   above.
//   The result sits in an output register; the next command is accepted
//   while it waits. If the receiver stalls, a second result holds the
//   sequencer until the output register frees.
//   Reset (rst, synchronous) empties the list, clears all slot-in-use bits
//   and the free-slot stack, and drops any pending result. The node
//   memories are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_recency_list_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // command beat: command[2:0], handle[10:3], payload_in[42:11]
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [lrl_pkg::IN_TDATA_W-1:0]    s_tdata,
  // result beat: payload_out[31:0], slot_out[39:32], status[42:40],
  // occupancy[51:43]
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [lrl_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  lrl_pkg::mem_req_t req;
  lrl_pkg::mem_rsp_t rsp;
  lrl_pkg::result_t  res;
  logic              res_valid;
  logic              res_ready;

  lrl_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .in_ready  (s_tready),
    .req       (req),
    .rsp       (rsp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // payload words
  lrl_ram #(.WIDTH(lrl_pkg::PAYLOAD_BITS), .DEPTH(lrl_pkg::SLOTS)) u_pl_ram (
    .clk   (clk),
    .we    (req.pl_we),
    .waddr (req.pl_waddr),
    .wdata (req.pl_wdata),
    .raddr (req.pl_raddr),
    .rdata (rsp.pl)
  );

  // links toward the head
  lrl_ram #(.WIDTH(lrl_pkg::SLOT_W), .DEPTH(lrl_pkg::SLOTS)) u_thl_ram (
    .clk   (clk),
    .we    (req.thl_we),
    .waddr (req.thl_waddr),
    .wdata (req.thl_wdata),
    .raddr (req.lk_raddr),
    .rdata (rsp.thl)
  );

  // links toward the tail
  lrl_ram #(.WIDTH(lrl_pkg::SLOT_W), .DEPTH(lrl_pkg::SLOTS)) u_ttl_ram (
    .clk   (clk),
    .we    (req.ttl_we),
    .waddr (req.ttl_waddr),
    .wdata (req.ttl_wdata),
    .raddr (req.lk_raddr),
    .rdata (rsp.ttl)
  );

  // stack of freed slots
  lrl_ram #(.WIDTH(lrl_pkg::SLOT_W), .DEPTH(lrl_pkg::SLOTS)) u_fs_ram (
    .clk   (clk),
    .we    (req.fs_we),
    .waddr (req.fs_waddr),
    .wdata (req.fs_wdata),
    .raddr (req.fs_raddr),
    .rdata (rsp.fs)
  );

  // output register: take a result when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= lrl_pkg::OUT_TDATA_W'(res);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lrl_ram.sv
// ----------------------------------------------------------------------------
// lrl_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/lrl_seq.sv
// ----------------------------------------------------------------------------
// lrl_seq: command sequencer of the LRU recency list
// Holds head, tail, counts and slot-in-use bits, and steps each command
// through reads and writes of the node memories one step at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lrl_seq (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic [lrl_pkg::IN_TDATA_W-1:0]  in_data,
  output logic                                 in_ready,
  output lrl_pkg::mem_req_t                    req,
  input  wire lrl_pkg::mem_rsp_t               rsp,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output lrl_pkg::result_t                     res
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DECODE = 8'b0000_0010,
    ST_LOAD   = 8'b0000_0100,
    ST_PREVD  = 8'b0000_1000,
    ST_UNLINK = 8'b0001_0000,
    ST_LINK   = 8'b0010_0000,
    ST_HEAD   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // latched command
  lrl_pkg::cmd_t                        cmd;
  logic [lrl_pkg::HANDLE_W-1:0]         hnd;
  logic [lrl_pkg::PIN_W-1:0]            pin;

  // list state
  logic [lrl_pkg::SLOT_W-1:0]           head;
  logic [lrl_pkg::SLOT_W-1:0]           tail;
  logic [lrl_pkg::CNT_W-1:0]            count;
  logic [lrl_pkg::CNT_W-1:0]            free_depth;
  logic [lrl_pkg::CNT_W-1:0]            fresh;
  logic [lrl_pkg::SLOTS-1:0]            in_use;

  // working registers
  logic [lrl_pkg::SLOT_W-1:0]           slot_r;
  logic [lrl_pkg::SLOT_W-1:0]           up;
  logic [lrl_pkg::SLOT_W-1:0]           down;
  logic [lrl_pkg::PAYLOAD_BITS-1:0]     pay;
  lrl_pkg::stat_t                       status;

  // decode helpers
  lrl_pkg::stat_t                       dec_status;
  state_t                               dec_next;
  logic [lrl_pkg::SLOT_W-1:0]           dec_addr;
  logic                                 full;
  logic                                 empty;
  logic                                 hnd_ok;
  logic                                 hnd_head;
  logic                                 fresh_ok;
  logic                                 fs_room;
  logic                                 is_head;
  logic                                 is_tail;
  logic [lrl_pkg::CNT_W-1:0]            fd_dec;

  assign full     = (count == lrl_pkg::CNT_W'(lrl_pkg::SLOTS));
  assign empty    = (count == '0);
  assign hnd_ok   = in_use[hnd[lrl_pkg::SLOT_W-1:0]];
  assign hnd_head = (hnd[lrl_pkg::SLOT_W-1:0] == head);
  assign fresh_ok = (fresh < lrl_pkg::CNT_W'(lrl_pkg::SLOTS));
  assign fs_room  = (free_depth < lrl_pkg::CNT_W'(lrl_pkg::SLOTS));
  assign is_head  = (slot_r == head);
  assign is_tail  = (slot_r == tail);
  assign fd_dec   = free_depth - lrl_pkg::CNT_W'(1);

  // classify the command and pick the first step
  always_comb begin
    dec_status = lrl_pkg::STAT_OK;
    dec_next   = ST_DONE;
    dec_addr   = hnd[lrl_pkg::SLOT_W-1:0];
    case (cmd)
      lrl_pkg::CMD_PUSH: begin
        if (full) begin
          dec_status = lrl_pkg::STAT_FULL;
        end else if (free_depth != '0) begin
          dec_next = ST_LOAD;
        end else if (fresh_ok) begin
          dec_next = ST_LINK;
        end else begin
          dec_status = lrl_pkg::STAT_FULL;
        end
      end
      lrl_pkg::CMD_POP, lrl_pkg::CMD_PEEK: begin
        dec_addr = tail;
        if (empty) begin
          dec_status = lrl_pkg::STAT_EMPTY;
        end else begin
          dec_next = ST_LOAD;
        end
      end
      lrl_pkg::CMD_TOUCH: begin
        if (!hnd_ok) begin
          dec_status = lrl_pkg::STAT_BADHND;
        end else if (!hnd_head) begin
          dec_next = ST_LOAD;
        end
      end
      lrl_pkg::CMD_REMOVE: begin
        if (!hnd_ok) begin
          dec_status = lrl_pkg::STAT_BADHND;
        end else begin
          dec_next = ST_LOAD;
        end
      end
      lrl_pkg::CMD_PREV: begin
        if (!hnd_ok) begin
          dec_status = lrl_pkg::STAT_BADHND;
        end else if (hnd_head) begin
          dec_status = lrl_pkg::STAT_ATHEAD;
        end else begin
          dec_next = ST_LOAD;
        end
      end
      default: begin
        dec_next = ST_DONE;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        state_next = dec_next;
      end
      ST_LOAD: begin
        case (cmd)
          lrl_pkg::CMD_PUSH: state_next = ST_LINK;
          lrl_pkg::CMD_PREV: state_next = ST_PREVD;
          lrl_pkg::CMD_PEEK: state_next = ST_DONE;
          default:           state_next = ST_UNLINK;
        endcase
      end
      ST_PREVD: begin
        state_next = ST_DONE;
      end
      ST_UNLINK: begin
        state_next = (cmd == lrl_pkg::CMD_TOUCH) ? ST_LINK : ST_DONE;
      end
      ST_LINK: begin
        state_next = (cmd == lrl_pkg::CMD_PUSH && empty) ? ST_DONE : ST_HEAD;
      end
      ST_HEAD: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // memory accesses of each step
  always_comb begin
    req           = '0;
    req.pl_waddr  = slot_r;
    req.pl_wdata  = lrl_pkg::PAYLOAD_BITS'(pin);
    req.pl_raddr  = (state == ST_LOAD) ? rsp.thl : dec_addr;
    req.lk_raddr  = dec_addr;
    req.fs_raddr  = fd_dec[lrl_pkg::SLOT_W-1:0];
    req.fs_waddr  = free_depth[lrl_pkg::SLOT_W-1:0];
    req.fs_wdata  = slot_r;
    req.thl_waddr = slot_r;
    req.ttl_waddr = slot_r;
    case (state)
      ST_UNLINK: begin
        if (!is_head && !is_tail) begin
          req.ttl_we    = 1'b1;
          req.ttl_waddr = up;
          req.ttl_wdata = down;
          req.thl_we    = 1'b1;
          req.thl_waddr = down;
          req.thl_wdata = up;
        end
        req.fs_we = (cmd != lrl_pkg::CMD_TOUCH) && fs_room;
      end
      ST_LINK: begin
        req.thl_we    = 1'b1;
        req.thl_wdata = '0;
        req.ttl_we    = 1'b1;
        req.ttl_wdata = empty ? '0 : head;
        req.pl_we     = (cmd == lrl_pkg::CMD_PUSH);
      end
      ST_HEAD: begin
        req.thl_we    = 1'b1;
        req.thl_waddr = head;
        req.thl_wdata = slot_r;
      end
      default: begin
        req.thl_we = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      free_depth <= '0;
      fresh      <= '0;
      in_use     <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_DECODE: begin
          if (cmd == lrl_pkg::CMD_PUSH && dec_status == lrl_pkg::STAT_OK) begin
            if (free_depth != '0) begin
              free_depth <= fd_dec;
            end else begin
              fresh <= fresh + lrl_pkg::CNT_W'(1);
            end
          end
        end
        ST_UNLINK: begin
          if (is_head && is_tail) begin
            head <= '0;
            tail <= '0;
          end else if (is_head) begin
            head <= down;
          end else if (is_tail) begin
            tail <= up;
          end
          if (cmd != lrl_pkg::CMD_TOUCH) begin
            in_use[slot_r] <= 1'b0;
            if (fs_room) free_depth <= free_depth + lrl_pkg::CNT_W'(1);
            if (!empty) count <= count - lrl_pkg::CNT_W'(1);
          end
        end
        ST_LINK: begin
          if (cmd == lrl_pkg::CMD_PUSH) begin
            in_use[slot_r] <= 1'b1;
            count <= count + lrl_pkg::CNT_W'(1);
            if (empty) begin
              head <= slot_r;
              tail <= slot_r;
            end
          end
        end
        ST_HEAD: begin
          head <= slot_r;
        end
        default: begin
          head <= head;
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd <= lrl_pkg::cmd_t'(in_data[lrl_pkg::CMD_W-1:0]);
        hnd <= in_data[lrl_pkg::CMD_W +: lrl_pkg::HANDLE_W];
        pin <= in_data[lrl_pkg::CMD_W + lrl_pkg::HANDLE_W +: lrl_pkg::PIN_W];
      end
      ST_DECODE: begin
        status <= dec_status;
        pay    <= '0;
        slot_r <= (cmd == lrl_pkg::CMD_PUSH) ? fresh[lrl_pkg::SLOT_W-1:0] : dec_addr;
      end
      ST_LOAD: begin
        if (cmd == lrl_pkg::CMD_PUSH) begin
          slot_r <= rsp.fs;
        end
        up   <= rsp.thl;
        down <= rsp.ttl;
        if (cmd == lrl_pkg::CMD_POP || cmd == lrl_pkg::CMD_PEEK) begin
          pay <= rsp.pl;
        end
      end
      ST_PREVD: begin
        pay <= rsp.pl;
      end
      default: begin
        up <= up;
      end
    endcase
  end

  // result of the finished command
  always_comb begin
    res.payload_out = lrl_pkg::POUT_W'(pay);
    res.slot_out    = (cmd == lrl_pkg::CMD_PUSH && status == lrl_pkg::STAT_OK) ?
                      lrl_pkg::SLOT_OUT_W'(slot_r) : '0;
    res.status      = status;
    res.occupancy   = lrl_pkg::OCC_W'(count);
  end

  assign res_valid = (state == ST_DONE);
  assign in_ready  = (state == ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/lrl_checker.sv
// ----------------------------------------------------------------------------
// lrl_checker: port-level checks of the LRU recency list
// Watches the command and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lrl_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [lrl_pkg::IN_TDATA_W-1:0]  s_tdata,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [lrl_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // a command is worked on alone: no second beat right after one
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command accepted back to back");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // status code stays in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[42:40] <= lrl_pkg::STAT_ATHEAD)
    else $error("status code out of range");

  // occupancy never exceeds the slot count
  a_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[51:43] <= lrl_pkg::OCC_W'(lrl_pkg::SLOTS))
    else $error("occupancy out of range");

  // a slot is reported only with ok status
  a_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[39:32] != '0) |-> m_tdata[42:40] == lrl_pkg::STAT_OK)
    else $error("slot reported on a failed command");

endmodule

bind lru_recency_list_unit lrl_checker u_lrl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/sv/tb_lru_recency_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_recency_list_unit: self-checking bench for the LRU recency list
// Streams push, pop, peek, touch, remove and read-previous commands into the
// block. A behavioral copy of the slot table predicts each result beat, which
// is compared field by field. Both stream sides idle at random. The list is
// driven to full and back to empty so that slots are reused from the free
// stack.
// ----------------------------------------------------------------------------

module tb_lru_recency_list_unit;
  import lrl_pkg::*;

  localparam int CMD_COUNT      = 1550;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int CALM_FIRST     = 4000;
  localparam int CALM_LAST      = 7000;
  localparam int IDLE_PCT       = 38;

  // command codes that the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  // table copies: one runs ahead while commands are planned, one follows
  // the beats that the block has accepted
  localparam bit LOOKAHEAD = 1'b0;
  localparam bit ACCEPTED  = 1'b1;

  typedef enum int {MIX_PHASE, FILL_PHASE, DRAIN_PHASE} traffic_mode_t;

  typedef struct packed {
    logic                hold_for_drain;
    logic [PIN_W-1:0]    payload;
    logic [HANDLE_W-1:0] handle;
    logic [CMD_W-1:0]    cmd;
  } command_beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  command_beat_t command_q[$];
  result_t       outcome_q[$];
  int            bad_results = 0;
  int            results_seen = 0;
  int            stall_cycles = 0;
  int            cycle_count = 0;
  logic          calm;

  // node table, two copies side by side, indexed by {copy, slot}
  logic [PAYLOAD_BITS-1:0] node_payload [0:2*SLOTS-1];
  logic [SLOT_W-1:0]       link_up      [0:2*SLOTS-1];
  logic [SLOT_W-1:0]       link_down    [0:2*SLOTS-1];
  logic [SLOT_W-1:0]       free_slots   [0:2*SLOTS-1];
  bit                      in_use       [0:2*SLOTS-1];
  bit [CNT_W-1:0]          free_cnt  [0:1];
  bit [CNT_W-1:0]          fresh_cnt [0:1];
  bit [CNT_W-1:0]          live_cnt  [0:1];
  bit [SLOT_W-1:0]         head [0:1];
  bit [SLOT_W-1:0]         tail [0:1];

  lru_recency_list_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Detach a slot from the chain; links of the new head or tail are left stale.
  function automatic void detach_slot(bit cp, logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] up;
    logic [SLOT_W-1:0] down;
    up = link_up[{cp, s}];
    down = link_down[{cp, s}];
    if (s == head[cp] && s == tail[cp]) begin
      head[cp] = '0;
      tail[cp] = '0;
    end else if (s == head[cp]) begin
      head[cp] = down;
    end else if (s == tail[cp]) begin
      tail[cp] = up;
    end else begin
      link_down[{cp, up}] = down;
      link_up[{cp, down}] = up;
    end
  endfunction

  function automatic void release_slot(bit cp, logic [SLOT_W-1:0] s);
    in_use[{cp, s}] = 1'b0;
    if (free_cnt[cp] < SLOTS) begin
      free_slots[{cp, free_cnt[cp][SLOT_W-1:0]}] = s;
      free_cnt[cp]++;
    end
    if (live_cnt[cp] > 0) live_cnt[cp]--;
  endfunction

  function automatic void attach_head(bit cp, logic [SLOT_W-1:0] s);
    link_up[{cp, s}] = '0;
    if (live_cnt[cp] == 0) begin
      link_down[{cp, s}] = '0;
      head[cp] = s;
      tail[cp] = s;
    end else begin
      link_down[{cp, s}] = head[cp];
      link_up[{cp, head[cp]}] = s;
      head[cp] = s;
    end
  endfunction

  // Apply one command to a table copy and return the result beat it gives.
  function automatic result_t apply_command(bit cp, logic [CMD_W-1:0] cmd,
                                            logic [HANDLE_W-1:0] hnd,
                                            logic [PIN_W-1:0] pin);
    result_t           r;
    logic [SLOT_W-1:0] s;
    bit                got_slot;
    r = '0;
    r.status = STAT_OK;
    got_slot = 1'b0;
    case (cmd)
      CMD_PUSH: begin
        if (live_cnt[cp] >= SLOTS) begin
          r.status = STAT_FULL;
        end else if (free_cnt[cp] > 0) begin
          free_cnt[cp]--;
          s = free_slots[{cp, free_cnt[cp][SLOT_W-1:0]}];
          got_slot = 1'b1;
        end else if (fresh_cnt[cp] < SLOTS) begin
          s = fresh_cnt[cp][SLOT_W-1:0];
          fresh_cnt[cp]++;
          got_slot = 1'b1;
        end else begin
          r.status = STAT_FULL;
        end
        if (got_slot) begin
          in_use[{cp, s}] = 1'b1;
          node_payload[{cp, s}] = pin;
          attach_head(cp, s);
          live_cnt[cp]++;
          r.slot_out = s;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (live_cnt[cp] == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.payload_out = node_payload[{cp, tail[cp]}];
          if (cmd == CMD_POP) begin
            s = tail[cp];
            detach_slot(cp, s);
            release_slot(cp, s);
          end
        end
      end
      CMD_TOUCH: begin
        if (!in_use[{cp, hnd}]) begin
          r.status = STAT_BADHND;
        end else if (hnd != head[cp]) begin
          detach_slot(cp, hnd);
          attach_head(cp, hnd);
        end
      end
      CMD_REMOVE: begin
        if (!in_use[{cp, hnd}]) begin
          r.status = STAT_BADHND;
        end else begin
          detach_slot(cp, hnd);
          release_slot(cp, hnd);
        end
      end
      CMD_PREV: begin
        if (!in_use[{cp, hnd}]) begin
          r.status = STAT_BADHND;
        end else if (hnd == head[cp]) begin
          r.status = STAT_ATHEAD;
        end else begin
          r.payload_out = node_payload[{cp, link_up[{cp, hnd}]}];
        end
      end
      default: begin
      end
    endcase
    r.occupancy = live_cnt[cp];
    return r;
  endfunction

  task automatic plan_command(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] hnd,
                              logic [PIN_W-1:0] pin, logic hold);
    command_beat_t beat;
    beat.cmd = cmd;
    beat.handle = hnd;
    beat.payload = pin;
    beat.hold_for_drain = hold;
    command_q.push_back(beat);
    void'(apply_command(LOOKAHEAD, cmd, hnd, pin));
  endtask

  // Mostly live handles, some head and tail, the rest anywhere.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int                  r;
    int                  k;
    logic [HANDLE_W-1:0] h;
    r = $urandom_range(99);
    h = $urandom_range(255);
    if (live_cnt[LOOKAHEAD] == 0 || r >= 88) return h;
    if (r < 10) return head[LOOKAHEAD];
    if (r < 18) return tail[LOOKAHEAD];
    k = $urandom_range(live_cnt[LOOKAHEAD] - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (in_use[{LOOKAHEAD, 8'(i)}]) begin
        if (k == 0) return 8'(i);
        k--;
      end
    end
    return h;
  endfunction

  function automatic logic [PIN_W-1:0] pick_payload();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(traffic_mode_t mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      FILL_PHASE: begin
        if (r < 80) return CMD_PUSH;
        if (r < 83) return CMD_POP;
        if (r < 86) return CMD_PEEK;
        if (r < 92) return CMD_TOUCH;
        if (r < 94) return CMD_REMOVE;
        if (r < 99) return CMD_PREV;
      end
      DRAIN_PHASE: begin
        if (r < 6) return CMD_PUSH;
        if (r < 46) return CMD_POP;
        if (r < 52) return CMD_PEEK;
        if (r < 60) return CMD_TOUCH;
        if (r < 86) return CMD_REMOVE;
        if (r < 99) return CMD_PREV;
      end
      default: begin
        if (r < 25) return CMD_PUSH;
        if (r < 37) return CMD_POP;
        if (r < 47) return CMD_PEEK;
        if (r < 65) return CMD_TOUCH;
        if (r < 78) return CMD_REMOVE;
        if (r < 97) return CMD_PREV;
      end
    endcase
    return $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
  endfunction

  // Hold both sides busy for one window of the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end
  assign calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);

  // Command driver: predict on each accepted beat, then offer the next one.
  always @(posedge clk) begin : drive_commands
    command_beat_t done;
    command_beat_t nxt;
    logic          go;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        done = command_q.pop_front();
        outcome_q.push_back(apply_command(ACCEPTED, done.cmd, done.handle,
                                          done.payload));
      end
      if (!s_tvalid || s_tready) begin
        go = 1'b0;
        if (command_q.size() != 0) begin
          nxt = command_q[0];
          go = (calm || $urandom_range(99) >= IDLE_PCT) &&
               !(nxt.hold_for_drain && outcome_q.size() != 0);
          if (go) begin
            s_tdata <= {{(IN_TDATA_W-IN_BITS){1'b0}}, nxt.payload, nxt.handle, nxt.cmd};
          end
        end
        s_tvalid <= go;
      end
    end
  end

  // Result monitor: compare each result beat with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t seen;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (m_tvalid && m_tready) begin
        seen = result_t'(m_tdata[OUT_BITS-1:0]);
        if (outcome_q.size() == 0) begin
          if (bad_results < 10)
            $display("result %0d: unexpected beat %h", results_seen, seen);
          bad_results++;
        end else begin
          want = outcome_q.pop_front();
          if (seen.payload_out !== want.payload_out || seen.slot_out !== want.slot_out ||
              seen.status !== want.status || seen.occupancy !== want.occupancy) begin
            if (bad_results < 10)
              $display("result %0d: payload %h/%h slot %0d/%0d status %0d/%0d occ %0d/%0d",
                       results_seen, want.payload_out, seen.payload_out,
                       want.slot_out, seen.slot_out, want.status, seen.status,
                       want.occupancy, seen.occupancy);
            bad_results++;
          end
        end
        results_seen++;
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    traffic_mode_t     mode;
    int                planned;
    int                mode_left;
    int                linger;
    logic              hold_next;
    logic [CMD_W-1:0]  cmd;

    // directed: empty list, bad handles, single entry, head, tail and middle
    plan_command(CMD_PEEK,    8'd0,   32'h0,         1'b0);
    plan_command(CMD_POP,     8'd0,   32'h0,         1'b0);
    plan_command(CMD_TOUCH,   8'd0,   32'h0,         1'b0);
    plan_command(CMD_REMOVE,  8'd255, 32'hFFFF_FFFF, 1'b0);
    plan_command(CMD_PREV,    8'hAA,  32'h0,         1'b0);
    plan_command(CMD_PUSH,    8'd0,   32'h0,         1'b0);
    plan_command(CMD_PREV,    8'd0,   32'h0,         1'b0);
    plan_command(CMD_TOUCH,   8'd0,   32'h0,         1'b0);
    plan_command(CMD_PUSH,    8'd255, 32'hFFFF_FFFF, 1'b0);
    plan_command(CMD_PUSH,    8'd0,   32'h5A5A_5A5A, 1'b0);
    plan_command(CMD_PREV,    8'd0,   32'h0,         1'b0);
    plan_command(CMD_TOUCH,   8'd0,   32'h0,         1'b0);
    plan_command(CMD_PEEK,    8'd0,   32'h0,         1'b0);
    plan_command(CMD_PREV,    8'd2,   32'h0,         1'b0);
    plan_command(CMD_REMOVE,  8'd2,   32'h0,         1'b0);
    plan_command(CMD_SPARE_A, 8'd255, 32'hFFFF_FFFF, 1'b0);
    plan_command(CMD_SPARE_B, 8'd0,   32'h0,         1'b0);
    plan_command(CMD_POP,     8'd0,   32'h0,         1'b0);
    plan_command(CMD_PUSH,    8'd0,   32'hA5A5_0001, 1'b0);
    plan_command(CMD_REMOVE,  8'd1,   32'h0,         1'b0);
    plan_command(CMD_TOUCH,   8'd1,   32'h0,         1'b0);
    plan_command(CMD_REMOVE,  8'd0,   32'h0,         1'b0);
    plan_command(CMD_PREV,    8'd0,   32'h0,         1'b0);
    plan_command(CMD_PUSH,    8'd0,   32'h1234_5678, 1'b0);

    // random: mixed traffic, then fill to full and drain to empty, repeated
    planned = 0;
    mode = MIX_PHASE;
    mode_left = 200;
    linger = 0;
    hold_next = 1'b0;
    while (planned < CMD_COUNT) begin
      cmd = pick_command(mode);
      plan_command(cmd, pick_handle(), pick_payload(), hold_next);
      hold_next = 1'b0;
      if (cmd != CMD_SPARE_A && cmd != CMD_SPARE_B) planned++;
      case (mode)
        MIX_PHASE: begin
          mode_left--;
          if (mode_left == 0) begin
            mode = FILL_PHASE;
            linger = 16;
          end
        end
        FILL_PHASE: begin
          if (live_cnt[LOOKAHEAD] == SLOTS) begin
            if (linger == 0) begin
              mode = DRAIN_PHASE;
              linger = 8;
              hold_next = 1'b1;
            end else begin
              linger--;
            end
          end
        end
        default: begin
          if (live_cnt[LOOKAHEAD] == 0) begin
            if (linger == 0) begin
              mode = MIX_PHASE;
              mode_left = 150;
              hold_next = 1'b1;
            end else begin
              linger--;
            end
          end
        end
      endcase
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (command_q.size() != 0 || outcome_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (bad_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
